/* src/bsef_pkg.sv */
// ----------------------------------------------------------------------------
// bsef_pkg
// Shared types, constants and helpers for the balance feedback core.
// ----------------------------------------------------------------------------
package bsef_pkg;

	localparam int FRAC_BITS = 16;
	localparam int WORD_W    = 32;
	localparam int PERIOD_W  = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_BITS  = WORD_W + 1 + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_BITS);
	localparam int PROD_W    = 64;
	localparam int ACC_W     = 52;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_WA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_TA = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_WR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_TR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EQ_CMD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EQ_WA   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EQ_TA   = 3'd6;

	// gain reset values given at Q16.16, rescaled to FRAC_BITS
	localparam longint GAIN_WA_Q16 = 43909;
	localparam longint GAIN_TA_Q16 = 1304510;
	localparam longint GAIN_WR_Q16 = 70432;
	localparam longint GAIN_TR_Q16 = 128542;

	function automatic logic signed [WORD_W-1:0] scale_reset(input longint v);
		longint r;
		if (FRAC_BITS >= 16) begin
			r = v <<< (FRAC_BITS - 16);
		end else begin
			r = v >>> (16 - FRAC_BITS);
		end
		return r[WORD_W-1:0];
	endfunction

	// clamp a wide signed value to the 32-bit range
	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(64'sh7fffffff);
		lo = -hi - PROD_W'(1);
		if (v > hi) begin
			return hi[WORD_W-1:0];
		end else if (v < lo) begin
			return lo[WORD_W-1:0];
		end
		return v[WORD_W-1:0];
	endfunction

	// round to nearest, ties toward plus infinity, then drop fraction bits
	function automatic logic signed [PROD_W-1:0] round_frac(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] half;
		half = PROD_W'(1) <<< (FRAC_BITS - 1);
		return (v + half) >>> FRAC_BITS;
	endfunction

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_TILT_MUL,
		OP_TILT_UPD,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_DONE,
		OP_TERM_MUL,
		OP_TERM_ACC,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] term;
	} dp_cmd_t;

endpackage

/* src/bsef_datapath.sv */
// ----------------------------------------------------------------------------
// bsef_datapath
// Registers, shared multiplier, serial divider and accumulator of the core.
// ----------------------------------------------------------------------------
module bsef_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bsef_pkg::dp_cmd_t                      cmd,
	input  logic signed [bsef_pkg::WORD_W-1:0]     motor_angle,
	input  logic signed [bsef_pkg::WORD_W-1:0]     gyro_rate,
	input  logic [bsef_pkg::PERIOD_W-1:0]          period,
	input  logic                                   cfg_wr,
	input  logic [bsef_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic signed [bsef_pkg::WORD_W-1:0]     cfg_data,
	output logic signed [bsef_pkg::WORD_W-1:0]     drive_command
);

	localparam int W  = bsef_pkg::WORD_W;
	localparam int PW = bsef_pkg::PROD_W;
	localparam int DB = bsef_pkg::DIV_BITS;
	localparam int FB = bsef_pkg::FRAC_BITS;
	localparam int RW = bsef_pkg::PERIOD_W;

	logic signed [W-1:0] gain_q [4];
	logic signed [W-1:0] eq_cmd_q, eq_wa_q, eq_ta_q;
	logic signed [W-1:0] wheel_angle_q, tilt_angle_q, wheel_rate_q, tilt_rate_q;
	logic signed [W-1:0] motor_q, gyro_q, ntilt_q, nwheel_q;
	logic [RW-1:0]       per_q;
	logic signed [PW-1:0] prod_q;
	logic signed [bsef_pkg::ACC_W-1:0] acc_q;
	logic [DB-1:0]       quo_q;
	logic [RW-1:0]       rem_q;
	logic                neg_q;

	logic signed [W-1:0]   new_wheel;
	logic signed [W:0]     diff;
	logic [W:0]            mag;
	logic [RW:0]           trial;
	logic signed [W-1:0]   dev;
	logic signed [PW-1:0]  quo_signed;
	logic signed [PW-1:0]  term_r;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0] <= bsef_pkg::scale_reset(bsef_pkg::GAIN_WA_Q16);
			gain_q[1] <= bsef_pkg::scale_reset(bsef_pkg::GAIN_TA_Q16);
			gain_q[2] <= bsef_pkg::scale_reset(bsef_pkg::GAIN_WR_Q16);
			gain_q[3] <= bsef_pkg::scale_reset(bsef_pkg::GAIN_TR_Q16);
			eq_cmd_q  <= '0;
			eq_wa_q   <= '0;
			eq_ta_q   <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				bsef_pkg::REG_GAIN_WA: gain_q[0] <= cfg_data;
				bsef_pkg::REG_GAIN_TA: gain_q[1] <= cfg_data;
				bsef_pkg::REG_GAIN_WR: gain_q[2] <= cfg_data;
				bsef_pkg::REG_GAIN_TR: gain_q[3] <= cfg_data;
				bsef_pkg::REG_EQ_CMD:  eq_cmd_q  <= cfg_data;
				bsef_pkg::REG_EQ_WA:   eq_wa_q   <= cfg_data;
				bsef_pkg::REG_EQ_TA:   eq_ta_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// combinational helpers
	always_comb begin
		new_wheel  = bsef_pkg::sat32(PW'(motor_q) + PW'(ntilt_q));
		diff       = (W+1)'(new_wheel) - (W+1)'(wheel_angle_q);
		mag        = diff[W] ? (W+1)'(-diff) : (W+1)'(diff);
		trial      = {rem_q, quo_q[DB-1]};
		quo_signed = neg_q ? -PW'({1'b0, quo_q}) : PW'({1'b0, quo_q});
		term_r     = bsef_pkg::round_frac(prod_q);
		case (cmd.term)
			2'd0:    dev = bsef_pkg::sat32(PW'(wheel_angle_q) - PW'(eq_wa_q));
			2'd1:    dev = bsef_pkg::sat32(PW'(tilt_angle_q) - PW'(eq_ta_q));
			2'd2:    dev = wheel_rate_q;
			default: dev = tilt_rate_q;
		endcase
	end

	// estimator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_angle_q <= '0;
			tilt_angle_q  <= '0;
			wheel_rate_q  <= '0;
			tilt_rate_q   <= '0;
		end else if (cmd.op == bsef_pkg::OP_DIV_DONE) begin
			wheel_rate_q  <= bsef_pkg::sat32(quo_signed);
			wheel_angle_q <= nwheel_q;
			tilt_angle_q  <= ntilt_q;
			tilt_rate_q   <= gyro_q;
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bsef_pkg::OP_LOAD: begin
				motor_q <= motor_angle;
				gyro_q  <= gyro_rate;
				per_q   <= (period == '0) ? RW'(1) : period;
			end
			bsef_pkg::OP_TILT_MUL: begin
				prod_q <= PW'(tilt_rate_q) * PW'($signed({1'b0, per_q}));
			end
			bsef_pkg::OP_TILT_UPD: begin
				ntilt_q <= bsef_pkg::sat32(PW'(tilt_angle_q) + term_r);
			end
			bsef_pkg::OP_DIV_INIT: begin
				nwheel_q <= new_wheel;
				neg_q    <= diff[W];
				rem_q    <= '0;
				quo_q    <= {mag, {FB{1'b0}}};
			end
			bsef_pkg::OP_DIV_STEP: begin
				if (trial >= {1'b0, per_q}) begin
					rem_q <= RW'(trial - {1'b0, per_q});
					quo_q <= {quo_q[DB-2:0], 1'b1};
				end else begin
					rem_q <= trial[RW-1:0];
					quo_q <= {quo_q[DB-2:0], 1'b0};
				end
			end
			bsef_pkg::OP_DIV_DONE: begin
				acc_q <= bsef_pkg::ACC_W'(eq_cmd_q);
			end
			bsef_pkg::OP_TERM_MUL: begin
				prod_q <= PW'(gain_q[cmd.term]) * PW'(dev);
			end
			bsef_pkg::OP_TERM_ACC: begin
				acc_q <= acc_q + bsef_pkg::ACC_W'(term_r);
			end
			bsef_pkg::OP_OUT_LOAD: begin
				drive_command <= bsef_pkg::sat32(PW'(acc_q) + term_r);
			end
			default: ;
		endcase
	end

endmodule

/* src/bsef_ctrl.sv */
// ----------------------------------------------------------------------------
// bsef_ctrl
// Sequencer for one control period: tilt, divide, four feedback terms.
// ----------------------------------------------------------------------------
module bsef_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output bsef_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_TMUL, S_TUPD, S_DINIT, S_DIV, S_DDONE, S_TERM_MUL, S_TERM_ACC
	} state_t;

	state_t                          state_q;
	logic [bsef_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [1:0]                      term_q;
	logic                            out_valid_q;
	logic                            out_free;
	logic                            in_xfer;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// decode datapath command from state
	always_comb begin
		cmd.term = term_q;
		unique case (state_q)
			S_IDLE:     cmd.op = in_xfer ? bsef_pkg::OP_LOAD : bsef_pkg::OP_IDLE;
			S_TMUL:     cmd.op = bsef_pkg::OP_TILT_MUL;
			S_TUPD:     cmd.op = bsef_pkg::OP_TILT_UPD;
			S_DINIT:    cmd.op = bsef_pkg::OP_DIV_INIT;
			S_DIV:      cmd.op = bsef_pkg::OP_DIV_STEP;
			S_DDONE:    cmd.op = bsef_pkg::OP_DIV_DONE;
			S_TERM_MUL: cmd.op = bsef_pkg::OP_TERM_MUL;
			S_TERM_ACC: cmd.op = (term_q != 2'd3) ? bsef_pkg::OP_TERM_ACC
			                     : (out_free ? bsef_pkg::OP_OUT_LOAD : bsef_pkg::OP_IDLE);
			default:    cmd.op = bsef_pkg::OP_IDLE;
		endcase
	end

	// advance the sequence; the final accumulate waits for a free output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			term_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_xfer) begin
					state_q <= S_TMUL;
				end
				S_TMUL:  state_q <= S_TUPD;
				S_TUPD:  state_q <= S_DINIT;
				S_DINIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == bsef_pkg::DIV_CNT_W'(bsef_pkg::DIV_BITS - 1)) begin
						state_q <= S_DDONE;
					end
				end
				S_DDONE: begin
					term_q  <= '0;
					state_q <= S_TERM_MUL;
				end
				S_TERM_MUL: state_q <= S_TERM_ACC;
				S_TERM_ACC: begin
					if (term_q != 2'd3) begin
						term_q  <= term_q + 1'b1;
						state_q <= S_TERM_MUL;
					end else if (out_free) begin
						// last term is folded into the output register; hold until free
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// check sequencing of one control period
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q < bsef_pkg::DIV_CNT_W'(bsef_pkg::DIV_BITS))
		else $error("divider step count overran");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_TMUL)
		else $error("accepted item did not start the sequence");
	a_out_from_acc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_TERM_ACC)
		else $error("result raised outside final accumulate");

endmodule

/* src/balance_state_estimator_feedback_core.sv */
// ----------------------------------------------------------------------------
// balance_state_estimator_feedback_core
// Four-state balance estimator and full-state feedback, Q16.16.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one control period: motor_angle,
// gyro_rate and period. The core updates tilt, wheel angle and wheel rate,
// then emits drive_command on the output channel (out_valid/out_stall).
// Configuration writes (cfg_valid/cfg_ready, always ready) set the gains and
// equilibrium values by index 0..6; other indexes are dropped.
// Each item runs from input transfer to out_valid through the tilt product
// and update, the 49-bit serial wheel-rate divider (one quotient bit per
// cycle) and a multiply and an accumulate step per feedback term on the
// shared multiplier. in_stall stays high while an item is in flight, so
// no new item is taken until the last one is through. A finished result
// sits in the output register while a new item is being worked; if the
// receiver still stalls when the next result is ready, the core holds in
// the last accumulate step. Reset clears the state to zero, restores the
// default gains and empties the output register.
// ----------------------------------------------------------------------------
module balance_state_estimator_feedback_core (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic signed [bsef_pkg::WORD_W-1:0]         motor_angle,
	input  logic signed [bsef_pkg::WORD_W-1:0]         gyro_rate,
	input  logic [bsef_pkg::PERIOD_W-1:0]              period,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic signed [bsef_pkg::WORD_W-1:0]         drive_command,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [bsef_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic signed [bsef_pkg::WORD_W-1:0]         cfg_data
);

	bsef_pkg::dp_cmd_t cmd;

	assign cfg_ready = 1'b1;

	bsef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	bsef_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.motor_angle   (motor_angle),
		.gyro_rate     (gyro_rate),
		.period        (period),
		.cfg_wr        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.drive_command (drive_command)
	);

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// Balance feedback core testbench
// Drives control periods into the core with random gaps and output stalls,
// predicts each drive command from a local copy of the estimator state and
// the register file, and checks every transfer in order. Register settings
// change between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_W    = bsef_pkg::WORD_W;
	localparam int PERIOD_W  = bsef_pkg::PERIOD_W;
	localparam int CFG_IDX_W = bsef_pkg::CFG_IDX_W;
	localparam int FRAC_BITS = bsef_pkg::FRAC_BITS;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_WA = bsef_pkg::REG_GAIN_WA;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_TA = bsef_pkg::REG_GAIN_TA;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_WR = bsef_pkg::REG_GAIN_WR;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_TR = bsef_pkg::REG_GAIN_TR;
	localparam logic [CFG_IDX_W-1:0] REG_EQ_CMD  = bsef_pkg::REG_EQ_CMD;
	localparam logic [CFG_IDX_W-1:0] REG_EQ_WA   = bsef_pkg::REG_EQ_WA;
	localparam logic [CFG_IDX_W-1:0] REG_EQ_TA   = bsef_pkg::REG_EQ_TA;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;
	localparam int     LATENCY = 80;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [WORD_W-1:0]   motor_angle;
	logic signed [WORD_W-1:0]   gyro_rate;
	logic [PERIOD_W-1:0]        period;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [WORD_W-1:0]   drive_command;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic signed [WORD_W-1:0]   cfg_data;

	balance_state_estimator_feedback_core dut (.*);

	// predictor state and register copy
	longint gain_reg [0:6];
	longint est_wheel, est_tilt, est_wrate, est_trate;
	logic signed [WORD_W-1:0] pending_cmd [$];
	int errors;
	int n_items, n_results, n_cfg;

	typedef struct {
		logic signed [WORD_W-1:0] motor;
		logic signed [WORD_W-1:0] gyro;
		logic [PERIOD_W-1:0]      per;
		bit                       known;
		logic signed [WORD_W-1:0] cmd;
	} stim_row_t;

	stim_row_t directed [$];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12ns * 5000000);
		$display("tb: failure");
		$finish;
	end

	function automatic longint clamp32(input longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	// round to nearest, ties up; >>> on longint floors
	function automatic longint round_q(input longint v);
		return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	endfunction

	task automatic reset_model();
		gain_reg[REG_GAIN_WA] = bsef_pkg::scale_reset(bsef_pkg::GAIN_WA_Q16);
		gain_reg[REG_GAIN_TA] = bsef_pkg::scale_reset(bsef_pkg::GAIN_TA_Q16);
		gain_reg[REG_GAIN_WR] = bsef_pkg::scale_reset(bsef_pkg::GAIN_WR_Q16);
		gain_reg[REG_GAIN_TR] = bsef_pkg::scale_reset(bsef_pkg::GAIN_TR_Q16);
		gain_reg[REG_EQ_CMD] = 0;
		gain_reg[REG_EQ_WA] = 0;
		gain_reg[REG_EQ_TA] = 0;
		est_wheel = 0; est_tilt = 0; est_wrate = 0; est_trate = 0;
	endtask

	// advance the estimator by one period and return the drive command
	function automatic logic signed [WORD_W-1:0] predict_command(
			input longint motor, input longint gyro, input longint per_in);
		longint per, nt, nw, acc;
		longint dev [0:3];
		per = (per_in == 0) ? 1 : per_in;
		nt = clamp32(est_tilt + round_q(est_trate * per));
		nw = clamp32(motor + nt);
		est_wrate = clamp32(((nw - est_wheel) * (64'sd1 <<< FRAC_BITS)) / per);
		est_wheel = nw;
		est_tilt = nt;
		est_trate = gyro;
		dev[0] = clamp32(est_wheel - gain_reg[REG_EQ_WA]);
		dev[1] = clamp32(est_tilt - gain_reg[REG_EQ_TA]);
		dev[2] = est_wrate;
		dev[3] = est_trate;
		acc = gain_reg[REG_EQ_CMD];
		for (int i = 0; i < 4; i++) acc += round_q(gain_reg[i] * dev[i]);
		return WORD_W'(clamp32(acc));
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx <= REG_EQ_TA) gain_reg[idx] = longint'($signed(val));
		n_cfg++;
		@(posedge clk);
	endtask

	// hold until the core has drained, then let it settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_cmd.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// send one period; a typed expectation replaces the predicted command
	task automatic send_period(input logic [WORD_W-1:0] m, input logic [WORD_W-1:0] g,
			input logic [PERIOD_W-1:0] p, input bit known,
			input logic signed [WORD_W-1:0] typed);
		int gap;
		logic signed [WORD_W-1:0] pred;
		gap = $urandom_range(0, 15) * ($urandom_range(0, 3) != 0);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		motor_angle <= m;
		gyro_rate <= g;
		period <= p;
		do @(posedge clk); while (in_stall);
		pred = predict_command(longint'($signed(m)), longint'($signed(g)), longint'(p));
		pending_cmd.push_back(known ? typed : pred);
		n_items++;
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 1) ? $urandom_range(0, 400000)
				: -$urandom_range(0, 400000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [PERIOD_W-1:0] rand_period();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 1) ? 16'hffff : 16'd1;
			1: return PERIOD_W'($urandom);
			default: return PERIOD_W'($urandom_range(200, 2000));
		endcase
	endfunction

	// output side: a drawn wait per result, in-order checking
	initial begin
		logic signed [WORD_W-1:0] want;
		int hold;
		out_stall = 1'b1;
		hold = $urandom_range(0, 15);
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_cmd.size() == 0) begin
					report_mismatch("unexpected drive_command", drive_command, 0);
				end else begin
					want = pending_cmd.pop_front();
					n_results++;
					if (drive_command !== want)
						report_mismatch("drive_command", drive_command, want);
				end
				hold = $urandom_range(0, 15);
			end else if (out_valid && hold != 0) begin
				hold--;
			end
			out_stall <= (hold != 0);
		end
	end

	initial begin
		errors = 0; n_items = 0; n_results = 0; n_cfg = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		motor_angle = '0; gyro_rate = '0; period = 16'd1;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		reset_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: zero rows expect zero, the rest are predicted
		directed.push_back(stim_row_t'{32'sd0, 32'sd0, 16'd1, 1'b1, 32'sd0});
		directed.push_back(stim_row_t'{32'sd0, 32'sd0, 16'd0, 1'b1, 32'sd0});
		directed.push_back(stim_row_t'{32'sh7fffffff, 32'sh7fffffff, 16'd1, 1'b0, 32'sd0});
		directed.push_back(stim_row_t'{32'sh7fffffff, 32'sh7fffffff, 16'hffff, 1'b0, 32'sd0});
		directed.push_back(stim_row_t'{32'sh80000000, 32'sh80000000, 16'd1, 1'b0, 32'sd0});
		directed.push_back(stim_row_t'{32'sh80000000, 32'sh80000000, 16'd0, 1'b0, 32'sd0});
		directed.push_back(stim_row_t'{32'sd65536, -32'sd65536, 16'd655, 1'b0, 32'sd0});
		directed.push_back(stim_row_t'{-32'sd1, 32'sd1, 16'hffff, 1'b0, 32'sd0});
		directed.push_back(stim_row_t'{32'sd0, 32'sd0, 16'h8000, 1'b0, 32'sd0});
		directed.push_back(stim_row_t'{32'sh55555555, 32'shaaaaaaaa, 16'h5555, 1'b0, 32'sd0});
		directed.push_back(stim_row_t'{32'shaaaaaaaa, 32'sh55555555, 16'haaaa, 1'b0, 32'sd0});
		foreach (directed[i]) begin
			send_period(directed[i].motor, directed[i].gyro, directed[i].per,
				directed[i].known, directed[i].cmd);
		end
		wait_idle();

		// extreme registers, an ignored index, then the most negative values
		for (int r = 0; r <= REG_EQ_TA; r++) write_reg(r[CFG_IDX_W-1:0], 32'h7fffffff);
		write_reg(3'd7, 32'h12345678);
		repeat (6) send_period(rand_word(), rand_word(), rand_period(), 1'b0, '0);
		wait_idle();
		for (int r = 0; r <= REG_EQ_TA; r++) write_reg(r[CFG_IDX_W-1:0], 32'h80000000);
		repeat (6) send_period(rand_word(), rand_word(), rand_period(), 1'b0, '0);
		wait_idle();

		// random phases, each with a random subset of registers rewritten
		for (int ph = 0; ph < 20; ph++) begin
			for (int r = 0; r <= 7; r++)
				if ($urandom_range(0, 2) != 0)
					write_reg(r[CFG_IDX_W-1:0], ($urandom_range(0, 3) == 0)
						? rand_word() : $urandom_range(0, 200000) - 100000);
			repeat (100) send_period(rand_word(), rand_word(), rand_period(), 1'b0, '0);
			wait_idle();
		end

		$display("tb: %0d periods sent, %0d commands checked, %0d register writes",
			n_items, n_results, n_cfg);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
